@@ hw/rtl/deadline_sorted_task_queue_assert.svh @@
// Assertion macros shared by the deadline-sorted task queue RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef DEADLINE_SORTED_TASK_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TASK_QUEUE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define DSTQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define DSTQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define DSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dstq_pkg.sv @@
// Types and constants for the deadline-sorted task queue.
// Used by the controller, the datapath and the top level; no dependencies.
package dstq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] task_id;
    logic [31:0] deadline;
  } in_req_t;

  typedef struct packed {
    logic        head_valid;
    logic [15:0] head_task_id;
    logic [31:0] head_deadline;
    logic [4:0]  occupancy;
    logic [1:0]  status;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       compare;
    logic       prefix;
    logic       do_insert;
    logic       do_remove;
    logic       respond;
    logic [1:0] status;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_remove;
    logic full;
    logic found;
  } dp_stat_t;

endpackage

@@ hw/rtl/dstq_ctrl.sv @@
// Sequencing state machine for the deadline-sorted task queue.
// Depends on dstq_pkg and the assertion macro header.
`include "deadline_sorted_task_queue_assert.svh"

module dstq_ctrl
  import dstq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PFX,
    S_UPD,
    S_RSP
  } state_t;

  state_t     st_r;
  logic [1:0] code_r;

  assign busy = (st_r != S_IDLE);

  always_comb begin
    dp_cmd           = '0;
    dp_cmd.load      = start && (st_r == S_IDLE);
    dp_cmd.compare   = (st_r == S_CMP);
    dp_cmd.prefix    = (st_r == S_PFX);
    dp_cmd.do_insert = (st_r == S_UPD) && !dp_stat.is_remove && !dp_stat.full;
    dp_cmd.do_remove = (st_r == S_UPD) && dp_stat.is_remove && dp_stat.found;
    dp_cmd.respond   = (st_r == S_RSP);
    dp_cmd.status    = code_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      code_r <= ST_OK;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            st_r <= S_CMP;
          end
        end
        S_CMP: st_r <= S_PFX;
        S_PFX: st_r <= S_UPD;
        S_UPD: begin
          st_r <= S_RSP;
          if (dp_stat.is_remove) begin
            code_r <= dp_stat.found ? ST_OK : ST_MISSING;
          end else begin
            code_r <= dp_stat.full ? ST_FULL : ST_OK;
          end
        end
        S_RSP: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `DSTQ_ASSERT_NEXT(a_accept_starts, start && !busy, st_r == S_CMP,
                    "accepted request did not start")
  `DSTQ_ASSERT_ALWAYS(a_one_update,
                      $countones({dp_cmd.do_insert, dp_cmd.do_remove}) <= 1,
                      "insert and remove applied together")
  `DSTQ_ASSERT_NEXT(a_update_then_respond, st_r == S_UPD, dp_cmd.respond,
                    "update not followed by response")

endmodule

@@ hw/rtl/dstq_datapath.sv @@
// Slot register chain, compare flags and result register of the task queue.
// Depends on dstq_pkg and the assertion macro header.
`include "deadline_sorted_task_queue_assert.svh"

module dstq_datapath
  import dstq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  dp_cmd_t  dp_cmd,
  output dp_stat_t dp_stat,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL   = $clog2(QUEUE_DEPTH);

  in_req_t                req_r;
  logic [31:0]            slot_dl_r [QUEUE_DEPTH];
  logic [15:0]            slot_id_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]       count_r;
  logic [QUEUE_DEPTH-1:0] lt_r;
  logic [QUEUE_DEPTH-1:0] match_r;
  logic [QUEUE_DEPTH-1:0] seen_r;
  logic [QUEUE_DEPTH-1:0] seen_nxt;
  logic [QUEUE_DEPTH-1:0] pfx [LVL+1];
  logic [31:0]            prev_dl [QUEUE_DEPTH];
  logic [15:0]            prev_id [QUEUE_DEPTH];
  logic [31:0]            next_dl [QUEUE_DEPTH];
  logic [15:0]            next_id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] prev_lt;
  logic                   out_valid_r;
  out_rsp_t               out_rsp_r;

  assign dp_stat.is_remove = (req_r.op == OP_REMOVE);
  assign dp_stat.full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign dp_stat.found     = seen_r[QUEUE_DEPTH-1];

  // Neighbor taps of each cell; the ends see the request or hold.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_taps
    if (g == 0) begin : g_first
      assign prev_dl[g] = req_r.deadline;
      assign prev_id[g] = req_r.task_id;
      assign prev_lt[g] = 1'b1;
    end else begin : g_mid
      assign prev_dl[g] = slot_dl_r[g-1];
      assign prev_id[g] = slot_id_r[g-1];
      assign prev_lt[g] = lt_r[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_dl[g] = slot_dl_r[g];
      assign next_id[g] = slot_id_r[g];
    end else begin : g_inner
      assign next_dl[g] = slot_dl_r[g+1];
      assign next_id[g] = slot_id_r[g+1];
    end
  end

  // Parallel prefix OR: seen marks the first id match and every cell after it.
  always_comb begin
    pfx[0] = match_r;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        pfx[l+1][i] = pfx[l][i];
        if (i >= (1 << l)) begin
          pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
        end
      end
    end
    seen_nxt = pfx[LVL];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      req_r <= in_req;
    end
    if (dp_cmd.compare) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        lt_r[i]    <= (CNT_W'(i) < count_r) && (slot_dl_r[i] < req_r.deadline);
        match_r[i] <= (CNT_W'(i) < count_r) && (slot_id_r[i] == req_r.task_id);
      end
    end
    if (dp_cmd.prefix) begin
      seen_r <= seen_nxt;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (dp_cmd.do_insert && !lt_r[i]) begin
        slot_dl_r[i] <= prev_lt[i] ? req_r.deadline : prev_dl[i];
        slot_id_r[i] <= prev_lt[i] ? req_r.task_id : prev_id[i];
      end else if (dp_cmd.do_remove && seen_r[i]) begin
        slot_dl_r[i] <= next_dl[i];
        slot_id_r[i] <= next_id[i];
      end
    end
    if (dp_cmd.respond) begin
      out_rsp_r.head_valid    <= (count_r != '0);
      out_rsp_r.head_task_id  <= (count_r != '0) ? slot_id_r[0] : 16'd0;
      out_rsp_r.head_deadline <= (count_r != '0) ? slot_dl_r[0] : 32'd0;
      out_rsp_r.occupancy     <= 5'(count_r);
      out_rsp_r.status        <= dp_cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_cmd.respond;
      if (dp_cmd.do_insert) begin
        count_r <= count_r + 1'b1;
      end else if (dp_cmd.do_remove) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `DSTQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH),
                      "slot count above depth")
  `DSTQ_ASSERT_NEXT(a_insert_grows, dp_cmd.do_insert,
                    count_r == $past(count_r) + 1'b1,
                    "insert did not grow count")
  `DSTQ_ASSERT_SAME(a_head_matches_count, out_valid_r,
                    out_rsp_r.head_valid == (count_r != '0),
                    "head valid disagrees with count")

endmodule

@@ hw/rtl/deadline_sorted_task_queue.sv @@
// Top level of the deadline-sorted task queue for an EDF scheduler.
// Depends on dstq_pkg, dstq_ctrl and dstq_datapath.

// The queue holds up to QUEUE_DEPTH tasks sorted by absolute deadline, the
// earliest at the head. A request is taken at a rising edge where start is
// high and busy is low; in_req.op selects an insert (placed ahead of the
// first held task whose deadline is not earlier, so ties go in front) or a
// removal of the first task, counted from the head, with a matching id.
// Every request yields exactly one response, shown on out_rsp for a single
// cycle while out_valid is high; the receiver cannot stall it, so it must
// capture the response in that cycle. A request passes from the accepting
// edge, which registers it, through the steps that compare every slot
// against it, resolve the first id match with a prefix network, shift the
// slot chain and load the response register, and then the response is
// shown. busy falls in the cycle the response is shown, so a new request
// can be accepted while the previous response is shown. One request is in
// flight at a time, since each one works on the list that the previous
// left.
// Occupancy is reported in a 5-bit field and wraps for depths above 31.
// After reset the queue is empty; no clearing pass is needed.

module deadline_sorted_task_queue
  import dstq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // The controller sequences each request through its compare, prefix,
  // update and response steps.
  dstq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd)
  );

  // The datapath holds the sorted slot chain and the response register.
  dstq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
